// File: src/breakpoint_envelope_interpolator_defines.svh
// Assertion macros used by the envelope interpolator checker
`ifndef BREAKPOINT_ENVELOPE_INTERPOLATOR_DEFINES_SVH
`define BREAKPOINT_ENVELOPE_INTERPOLATOR_DEFINES_SVH

// check c in the cycle after a, outside reset
`define BEI_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

// check c in the cycle after a, also across reset
`define BEI_ASSERT_NEXT_ANY(lbl, clk, a, c, msg) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) else $error(msg);

`endif

// File: src/bei_pkg.sv
// Package: types, constants and conversion functions of the envelope interpolator
`timescale 1ns / 1ps
package bei_pkg;

  localparam int MAX_SEG_DEF   = 63;
  localparam int TICK_BITS_DEF = 24;

  localparam int TICK_W  = 24;
  localparam int LEVEL_W = 18;
  localparam int VALUE_W = 16;
  localparam int STEP_W  = 24;
  localparam int CC_W    = 7;
  localparam int QUOT_W  = 18;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'd256;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 18'sd65536;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -18'sd65536;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_STEP = 1'b1;

  typedef struct packed {
    logic load;
    logic setup;
    logic mul;
    logic div_init;
    logic div_step;
    logic conv;
    logic skip_pt;
    logic push_pt;
    logic push_fin;
    logic flush;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic ramp;
    logic fin;
    logic point_ok;
    logic div_last;
    logic keep;
    logic can_push;
    logic pend;
    logic out_free;
  } stat_t;

  function automatic logic signed [VALUE_W-1:0] to_cents16(logic signed [LEVEL_W-1:0] lv);
    logic signed [24:0] p;
    p = 25'(lv) * 25'sd75;
    if (p < 0) begin
      p = p + 25'sd255;
    end
    return VALUE_W'(p >>> 8);
  endfunction

  function automatic logic [CC_W-1:0] to_cc(logic signed [LEVEL_W-1:0] lv);
    logic signed [24:0] x;
    logic [CC_W:0] y;
    x = 25'(lv) * 25'sd127 + 25'sd32768;
    y = x[23:16];
    if (x < 0) begin
      return '0;
    end else if (y > 8'd127) begin
      return 7'd127;
    end else begin
      return y[CC_W-1:0];
    end
  endfunction

endpackage

// File: src/bei_regs.sv
// Configuration register file with APB-style access
`timescale 1ns / 1ps
module bei_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bei_pkg::ADDR_W-1:0]  paddr,
  input  logic [bei_pkg::DATA_W-1:0]  pwdata,
  output logic [bei_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic                        mode,
  output logic [bei_pkg::STEP_W-1:0]  step_ticks
);

  logic                       mode_r;
  logic [bei_pkg::STEP_W-1:0] step_r;
  logic                       wr;

  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      step_r <= bei_pkg::STEP_RESET;
    end else if (wr) begin
      case (paddr[2])
        bei_pkg::REG_MODE: mode_r <= pwdata[0];
        bei_pkg::REG_STEP: step_r <= pwdata[bei_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bei_pkg::REG_MODE: prdata = bei_pkg::DATA_W'(mode_r);
      bei_pkg::REG_STEP: prdata = bei_pkg::DATA_W'(step_r);
      default:           prdata = '0;
    endcase
  end

  assign mode       = mode_r;
  assign step_ticks = step_r;

endmodule

// File: src/bei_ctrl.sv
// Controller state machine sequencing ramp points, division and result hand-off
`timescale 1ns / 1ps
module bei_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  bei_pkg::stat_t  st,
  output bei_pkg::cmd_t   cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SETUP = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_DINIT = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_CONV  = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_FLUSH = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   final_r, final_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      final_r <= final_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    final_nxt = final_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        final_nxt = 1'b0;
        state_nxt = st.ramp ? S_CHECK : S_FLUSH;
      end
      S_CHECK: begin
        if (st.point_ok) begin
          cmd.mul   = 1'b1;
          state_nxt = S_DINIT;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!st.keep) begin
          cmd.skip_pt = 1'b1;
          state_nxt   = S_CHECK;
        end else if (st.can_push) begin
          cmd.push_pt = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_FLUSH: begin
        if (st.fin && !final_r) begin
          if (st.can_push) begin
            cmd.push_fin = 1'b1;
            final_nxt    = 1'b1;
          end
        end else if (!st.pend) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end else if (st.out_free) begin
          cmd.flush  = 1'b1;
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: src/bei_dp.sv
// Datapath: envelope state, point stepping, shift-subtract divider and result stages
`timescale 1ns / 1ps
module bei_dp #(
  parameter int MAX_SEGMENT_POINTS = bei_pkg::MAX_SEG_DEF,
  parameter int TICK_BITS          = bei_pkg::TICK_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bei_pkg::cmd_t                       cmd,
  output bei_pkg::stat_t                      st,
  input  logic                                mode,
  input  logic [bei_pkg::STEP_W-1:0]          step_ticks,
  input  logic [bei_pkg::TICK_W-1:0]          in_node_tick,
  input  logic signed [bei_pkg::LEVEL_W-1:0]  in_node_value,
  input  logic                                in_is_final,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bei_pkg::TICK_W-1:0]          out_event_tick,
  output logic signed [bei_pkg::VALUE_W-1:0]  out_event_value,
  output logic                                out_last_of_run,
  output logic                                out_overflow
);

  localparam int TW = (TICK_BITS < bei_pkg::TICK_W) ? TICK_BITS : bei_pkg::TICK_W;
  localparam int SW = TW + 8;
  localparam int KW = $clog2(MAX_SEGMENT_POINTS + 1);
  localparam int LW = bei_pkg::LEVEL_W;
  localparam int QW = bei_pkg::QUOT_W;
  localparam int NW = SW + QW;
  localparam int VW = bei_pkg::VALUE_W;

  logic [TW-1:0]        cur_tick_r, prev_tick_r;
  logic signed [LW-1:0] cur_level_r, prev_level_r, lv_r;
  logic                 fin_r, ramp_r, have_prev_r, ovf_r, dv_neg_r;
  logic [SW-1:0]        span_r, rem_r;
  logic [LW-1:0]        dv_mag_r;
  logic [SW:0]          off_r;
  logic [KW-1:0]        k_r;
  logic [NW-1:0]        num_r;
  logic [QW-1:0]        quot_r;
  logic [4:0]           cnt_r;
  logic [bei_pkg::CC_W-1:0] last_cc_r;
  logic                 cc_valid_r;

  logic                 pend_r, out_valid_r, out_last_r;
  logic [bei_pkg::TICK_W-1:0] pend_tick_r, out_tick_r;
  logic signed [VW-1:0] pend_val_r, out_val_r;
  logic                 pend_ovf_r, out_ovf_r;

  logic [TW-1:0]        tick_in;
  logic signed [LW-1:0] lvl_in;
  logic signed [LW:0]   dv;
  logic [SW-1:0]        step_eff;
  logic [SW+6:0]        lim;
  logic [QW-1:0]        num_lo;
  logic [SW:0]          trial;
  logic                 qbit;
  logic signed [LW:0]   lv_sum;
  logic signed [LW-1:0] val_lv;
  logic [bei_pkg::CC_W-1:0] cc;
  logic signed [VW-1:0] val;
  logic [bei_pkg::TICK_W-1:0] pt_tick, res_tick;
  logic                 push, out_free;

  assign tick_in = in_node_tick[TW-1:0];

  always_comb begin
    if (in_node_value > bei_pkg::LEVEL_MAX) begin
      lvl_in = bei_pkg::LEVEL_MAX;
    end else if (in_node_value < bei_pkg::LEVEL_MIN) begin
      lvl_in = bei_pkg::LEVEL_MIN;
    end else begin
      lvl_in = in_node_value;
    end
  end

  assign dv       = (LW+1)'(lvl_in) - (LW+1)'(prev_level_r);
  assign step_eff = (step_ticks == '0) ? SW'(1) : SW'(step_ticks);
  assign lim      = (SW+7)'(MAX_SEGMENT_POINTS) * (SW+7)'(step_eff);
  assign num_lo   = num_r[QW-1:0];
  assign trial    = {rem_r, num_lo[cnt_r]};
  assign qbit     = (trial >= {1'b0, span_r});
  assign lv_sum   = dv_neg_r ? ((LW+1)'(prev_level_r) - (LW+1)'({1'b0, quot_r}))
                             : ((LW+1)'(prev_level_r) + (LW+1)'({1'b0, quot_r}));
  assign val_lv   = cmd.push_fin ? cur_level_r : lv_r;
  assign cc       = bei_pkg::to_cc(val_lv);
  assign val      = mode ? VW'(cc) : bei_pkg::to_cents16(val_lv);
  assign pt_tick  = bei_pkg::TICK_W'(prev_tick_r) + bei_pkg::TICK_W'(off_r[SW-1:8]);
  assign res_tick = cmd.push_fin ? bei_pkg::TICK_W'(cur_tick_r) : pt_tick;
  assign push     = cmd.push_pt || cmd.push_fin;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_tick_r  <= '0;
      prev_level_r <= '0;
      have_prev_r  <= 1'b0;
      last_cc_r    <= '0;
      cc_valid_r   <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.push_pt && mode) begin
        last_cc_r  <= cc;
        cc_valid_r <= 1'b1;
      end
      if (cmd.push_fin && mode) begin
        last_cc_r <= cc;
      end
      if (cmd.commit) begin
        prev_tick_r  <= cur_tick_r;
        prev_level_r <= cur_level_r;
        have_prev_r  <= !fin_r;
        if (fin_r) begin
          cc_valid_r <= 1'b0;
        end
      end
      if (push) begin
        pend_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_r <= 1'b0;
      end
      if ((push && pend_r) || cmd.flush) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_tick_r  <= tick_in;
      cur_level_r <= lvl_in;
      fin_r       <= in_is_final;
      ramp_r      <= have_prev_r && (lvl_in != prev_level_r) && (tick_in >= prev_tick_r);
      span_r      <= {tick_in - prev_tick_r, 8'h00};
      dv_neg_r    <= dv[LW];
      dv_mag_r    <= dv[LW] ? LW'(-dv) : LW'(dv);
    end
    if (cmd.setup) begin
      off_r <= '0;
      k_r   <= '0;
      ovf_r <= ramp_r && ((SW+7)'(span_r) >= lim);
    end
    if (cmd.mul) begin
      num_r <= NW'(dv_mag_r) * NW'(off_r[SW-1:0]);
    end
    if (cmd.div_init) begin
      rem_r <= num_r[NW-1:QW];
      cnt_r <= 5'(QW - 1);
    end
    if (cmd.div_step) begin
      rem_r  <= qbit ? SW'(trial - {1'b0, span_r}) : trial[SW-1:0];
      quot_r <= {quot_r[QW-2:0], qbit};
      cnt_r  <= cnt_r - 5'd1;
    end
    if (cmd.conv) begin
      lv_r <= (span_r == '0) ? cur_level_r : LW'(lv_sum);
    end
    if (cmd.push_pt || cmd.skip_pt) begin
      off_r <= off_r + (SW+1)'(step_eff);
      k_r   <= k_r + KW'(1);
    end
    if (push) begin
      pend_tick_r <= res_tick;
      pend_val_r  <= val;
      pend_ovf_r  <= ovf_r;
    end
    if ((push && pend_r) || cmd.flush) begin
      out_tick_r <= pend_tick_r;
      out_val_r  <= pend_val_r;
      out_ovf_r  <= pend_ovf_r;
      out_last_r <= cmd.flush;
    end
  end

  always_comb begin
    st.ramp     = ramp_r;
    st.fin      = fin_r;
    st.point_ok = (off_r <= {1'b0, span_r}) && (k_r < KW'(MAX_SEGMENT_POINTS));
    st.div_last = (cnt_r == '0);
    st.keep     = !mode || !cc_valid_r || (cc != last_cc_r);
    st.can_push = !pend_r || out_free;
    st.pend     = pend_r;
    st.out_free = out_free;
  end

  assign out_valid       = out_valid_r;
  assign out_event_tick  = out_tick_r;
  assign out_event_value = out_val_r;
  assign out_last_of_run = out_last_r;
  assign out_overflow    = out_ovf_r;

endmodule

// File: src/breakpoint_envelope_interpolator.sv
// Top level of the breakpoint envelope interpolator
`timescale 1ns / 1ps
// One breakpoint item is taken at a time; in_stall stays high until all of its
// events have left the internal holding stage. Each ramp point runs through
// multiply, divider init, an 18-step shift-subtract divider, convert and emit;
// emit waits while a held event cannot move on because out_stall holds the
// output register. The divider loop sets the rate. One event is held back
// internally so that last_of_run can be marked after repeat suppression in
// controller mode.
module breakpoint_envelope_interpolator #(
  parameter int MAX_SEGMENT_POINTS = bei_pkg::MAX_SEG_DEF,
  parameter int TICK_BITS          = bei_pkg::TICK_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bei_pkg::TICK_W-1:0]          in_node_tick,
  input  logic signed [bei_pkg::LEVEL_W-1:0]  in_node_value,
  input  logic                                in_is_final,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bei_pkg::TICK_W-1:0]          out_event_tick,
  output logic signed [bei_pkg::VALUE_W-1:0]  out_event_value,
  output logic                                out_last_of_run,
  output logic                                out_overflow,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bei_pkg::ADDR_W-1:0]          paddr,
  input  logic [bei_pkg::DATA_W-1:0]          pwdata,
  output logic [bei_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  bei_pkg::cmd_t              cmd;
  bei_pkg::stat_t             st;
  logic                       mode;
  logic [bei_pkg::STEP_W-1:0] step_ticks;

  bei_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .mode       (mode),
    .step_ticks (step_ticks)
  );

  bei_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  bei_dp #(
    .MAX_SEGMENT_POINTS (MAX_SEGMENT_POINTS),
    .TICK_BITS          (TICK_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .mode            (mode),
    .step_ticks      (step_ticks),
    .in_node_tick    (in_node_tick),
    .in_node_value   (in_node_value),
    .in_is_final     (in_is_final),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_tick  (out_event_tick),
    .out_event_value (out_event_value),
    .out_last_of_run (out_last_of_run),
    .out_overflow    (out_overflow)
  );

endmodule

// File: src/bei_checker.sv
// Port-level checker for the envelope interpolator, bound to the top level
`timescale 1ns / 1ps
`include "breakpoint_envelope_interpolator_defines.svh"
module bei_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [bei_pkg::TICK_W-1:0]          out_event_tick,
  input logic signed [bei_pkg::VALUE_W-1:0]  out_event_value,
  input logic                                out_last_of_run,
  input logic                                out_overflow
);

  `BEI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable({out_event_tick, out_event_value, out_last_of_run, out_overflow}),
    "stalled output item changed")
  `BEI_ASSERT_NEXT_ANY(a_reset_quiet, clk, !rst_n, !out_valid && !in_stall,
    "output valid or input stalled after reset")
  `BEI_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall,
    "second item taken while one is in work")

endmodule

bind breakpoint_envelope_interpolator bei_checker u_bei_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_event_tick  (out_event_tick),
  .out_event_value (out_event_value),
  .out_last_of_run (out_last_of_run),
  .out_overflow    (out_overflow)
);
